// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");

`endif

// ----- hw/rtl/ale_pkg.sv -----
// shared types and constants of the array list engine
package ale_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 8;
   localparam int FND_W    = 5;
   localparam int CMD_W    = 3;
   localparam int STAT_W   = 2;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 24;
   // result fields in use: read value, hit, status, count, full and empty flags
   localparam int RSP_USED = VAL_W + FND_W + STAT_W + CNT_W + 2;

   localparam logic [FND_W-1:0] FOUND_NONE = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_SEARCH = 3'd1,
      CMD_APPEND = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_MODIFY = 3'd4,
      CMD_REMOVE = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_RDWAIT,
      S_WALK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic judge;
      logic begin_walk;
      logic walk;
      logic put;
      logic inc;
      logic dec;
      logic rd_issue;
      logic rd_grab;
      logic post;
   } ctl_type;

   typedef struct packed {
      cmd_type  cmd;
      stat_type chk;
      logic     done;
      logic     out_free;
   } sts_type;

endpackage

// ----- hw/rtl/array_list_engine.sv -----
// Array list engine: an ordered list of up to CAPACITY bytes with an item count.
// The req channel takes one command word (read, search, append, insert, modify,
// remove); every command returns exactly one word on the rsp channel with the
// byte read, the search hit (-1 if none), a status code and the count after it.
// Commands are worked one at a time by a sequencer over a list ram with one
// write and one registered read port.
// Each command is checked first; then a read waits for the ram, a search walks the
// list until a hit or the end, and an insert or remove shifts the entries between
// the index and the end of the list; a finish step then posts the result.
// req_tready rises together with rsp_tvalid, so a new command is taken only after
// the previous one has posted its result.
// The result sits in an output register, so a new command is taken while the
// previous result still waits; a stalled receiver holds the block in its last
// step until the result register frees up.
// Reset empties the list (count zero) and drops any pending result; list
// contents are not cleared, entries are only read after being written.
module array_list_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // command[2:0], index[6:3], value[14:7], zero[15]
   input  logic [ale_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // read_value[7:0], found_index[12:8], status[14:13], count[19:15],
   // is_full[20], is_empty[21], zero[23:22]
   output logic [ale_pkg::RSP_W-1:0] rsp_tdata
);

   ale_pkg::ctl_type                ctl;
   ale_pkg::sts_type                sts;
   logic [ale_pkg::VAL_W-1:0]       read_value;
   logic [ale_pkg::FND_W-1:0]       found_index;
   logic [ale_pkg::STAT_W-1:0]      status;
   logic [ale_pkg::CNT_W-1:0]       count;
   logic                            is_full;
   logic                            is_empty;

   ale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   ale_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_command     (req_tdata[2:0]),
      .req_index       (req_tdata[6:3]),
      .req_value       (req_tdata[14:7]),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_read_value  (read_value),
      .rsp_found_index (found_index),
      .rsp_status      (status),
      .rsp_count       (count),
      .rsp_is_full     (is_full),
      .rsp_is_empty    (is_empty)
   );

   assign rsp_tdata = {{(ale_pkg::RSP_W - ale_pkg::RSP_USED){1'b0}},
                       is_empty, is_full, count, status, found_index, read_value};

endmodule

// ----- hw/rtl/ale_ram.sv -----
// generic single write port ram with registered read
module ale_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ale_datapath.sv -----
// list storage, item count, walk pointer and result register
module ale_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ale_pkg::ctl_type              ctl,
   output ale_pkg::sts_type              sts,
   input  logic [ale_pkg::CMD_W-1:0]     req_command,
   input  logic [ale_pkg::IDX_W-1:0]     req_index,
   input  logic [ale_pkg::VAL_W-1:0]     req_value,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic [ale_pkg::VAL_W-1:0]     rsp_read_value,
   output logic [ale_pkg::FND_W-1:0]     rsp_found_index,
   output logic [ale_pkg::STAT_W-1:0]    rsp_status,
   output logic [ale_pkg::CNT_W-1:0]     rsp_count,
   output logic                          rsp_is_full,
   output logic                          rsp_is_empty
);

   ale_pkg::cmd_type                cmd_ff, cmd_in;
   logic [ale_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [ale_pkg::VAL_W-1:0]       val_ff, val_in;
   logic [ale_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [ale_pkg::CNT_W-1:0]       ptr_ff, ptr_in;
   logic                            pend_ff, pend_in;
   logic [ale_pkg::IDX_W-1:0]       pend_addr_ff, pend_addr_in;
   logic [ale_pkg::FND_W-1:0]       found_ff, found_in;
   logic [ale_pkg::VAL_W-1:0]       rd_ff, rd_in;
   ale_pkg::stat_type               st_ff, st_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ale_pkg::VAL_W-1:0]       out_rd_ff, out_rd_in;
   logic [ale_pkg::FND_W-1:0]       out_found_ff, out_found_in;
   logic [ale_pkg::STAT_W-1:0]      out_st_ff, out_st_in;
   logic [ale_pkg::CNT_W-1:0]       out_count_ff, out_count_in;
   logic                            out_full_ff, out_full_in;
   logic                            out_empty_ff, out_empty_in;

   ale_pkg::stat_type               chk;
   logic [ale_pkg::CNT_W-1:0]       idx_ext;
   logic [ale_pkg::CNT_W-1:0]       walk_rd;
   logic                            more;
   logic                            match;
   logic                            ram_we;
   logic [ale_pkg::IDX_W-1:0]       ram_wa;
   logic [ale_pkg::VAL_W-1:0]       ram_wd;
   logic [ale_pkg::IDX_W-1:0]       ram_ra;
   logic [ale_pkg::VAL_W-1:0]       ram_rd;

   ale_ram #(
      .WIDTH (ale_pkg::VAL_W),
      .DEPTH (ale_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign idx_ext = ale_pkg::CNT_W'(idx_ff);

   // error check against the count before the command
   always_comb begin
      chk = ale_pkg::ST_OK;
      case (cmd_ff)
         ale_pkg::CMD_READ, ale_pkg::CMD_MODIFY, ale_pkg::CMD_REMOVE: begin
            if (count_ff == '0) begin
               chk = ale_pkg::ST_EMPTY;
            end else if (idx_ext >= count_ff) begin
               chk = ale_pkg::ST_RANGE;
            end
         end
         ale_pkg::CMD_APPEND: begin
            if (count_ff >= ale_pkg::CNT_W'(ale_pkg::CAPACITY)) begin
               chk = ale_pkg::ST_FULL;
            end
         end
         ale_pkg::CMD_INSERT: begin
            if (count_ff >= ale_pkg::CNT_W'(ale_pkg::CAPACITY)) begin
               chk = ale_pkg::ST_FULL;
            end else if (idx_ext > count_ff) begin
               chk = ale_pkg::ST_RANGE;
            end
         end
         default: ;
      endcase
   end

   // walk: insert moves down from the end, remove and search move up
   always_comb begin
      case (cmd_ff)
         ale_pkg::CMD_INSERT: begin
            more    = (ptr_ff != idx_ext);
            walk_rd = ptr_ff - ale_pkg::CNT_W'(1);
         end
         ale_pkg::CMD_REMOVE: begin
            more    = ((ptr_ff + ale_pkg::CNT_W'(1)) < count_ff);
            walk_rd = ptr_ff + ale_pkg::CNT_W'(1);
         end
         default: begin
            more    = (ptr_ff < count_ff);
            walk_rd = ptr_ff;
         end
      endcase
   end

   assign match = pend_ff && (cmd_ff == ale_pkg::CMD_SEARCH) && (ram_rd == val_ff);

   always_comb begin
      sts.cmd      = cmd_ff;
      sts.chk      = chk;
      sts.done     = match || (!more && !pend_ff);
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   // ram port control
   always_comb begin
      ram_we = 1'b0;
      ram_wa = idx_ff;
      ram_wd = val_ff;
      if (ctl.walk && pend_ff && (cmd_ff != ale_pkg::CMD_SEARCH)) begin
         ram_we = 1'b1;
         ram_wa = pend_addr_ff;
         ram_wd = ram_rd;
      end else if (ctl.put) begin
         ram_we = 1'b1;
         ram_wa = (cmd_ff == ale_pkg::CMD_APPEND) ? count_ff[ale_pkg::IDX_W-1:0] : idx_ff;
      end
      ram_ra = ctl.rd_issue ? idx_ff : walk_rd[ale_pkg::IDX_W-1:0];
   end

   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      found_in     = found_ff;
      rd_in        = rd_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      out_rd_in    = out_rd_ff;
      out_found_in = out_found_ff;
      out_st_in    = out_st_ff;
      out_count_in = out_count_ff;
      out_full_in  = out_full_ff;
      out_empty_in = out_empty_ff;

      if (ctl.load) begin
         cmd_in   = ale_pkg::cmd_type'(req_command);
         idx_in   = req_index;
         val_in   = req_value;
         rd_in    = '0;
         found_in = ale_pkg::FOUND_NONE;
      end
      if (ctl.judge) begin
         st_in = chk;
      end
      if (ctl.begin_walk) begin
         pend_in = 1'b0;
         case (cmd_ff)
            ale_pkg::CMD_INSERT: ptr_in = count_ff;
            ale_pkg::CMD_REMOVE: ptr_in = idx_ext;
            default:             ptr_in = '0;
         endcase
      end
      if (ctl.walk) begin
         pend_in      = more;
         pend_addr_in = ptr_ff[ale_pkg::IDX_W-1:0];
         if (more) begin
            ptr_in = (cmd_ff == ale_pkg::CMD_INSERT) ? ptr_ff - ale_pkg::CNT_W'(1)
                                                     : ptr_ff + ale_pkg::CNT_W'(1);
         end
         if (match) begin
            found_in = ale_pkg::FND_W'(pend_addr_ff);
         end
      end
      if (ctl.inc) begin
         count_in = count_ff + ale_pkg::CNT_W'(1);
      end
      if (ctl.dec) begin
         count_in = count_ff - ale_pkg::CNT_W'(1);
      end
      if (ctl.rd_grab) begin
         rd_in = ram_rd;
      end

      if (ctl.post) begin
         rsp_valid_in = 1'b1;
         out_rd_in    = rd_ff;
         out_found_in = found_ff;
         out_st_in    = st_ff;
         out_count_in = count_ff;
         out_full_in  = (count_ff == ale_pkg::CNT_W'(ale_pkg::CAPACITY));
         out_empty_in = (count_ff == '0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      found_ff     <= found_in;
      rd_ff        <= rd_in;
      st_ff        <= st_in;
      out_rd_ff    <= out_rd_in;
      out_found_ff <= out_found_in;
      out_st_ff    <= out_st_in;
      out_count_ff <= out_count_in;
      out_full_ff  <= out_full_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = out_rd_ff;
   assign rsp_found_index = out_found_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_count       = out_count_ff;
   assign rsp_is_full     = out_full_ff;
   assign rsp_is_empty    = out_empty_ff;

endmodule

// ----- hw/rtl/ale_ctrl.sv -----
// command sequencer of the array list engine
module ale_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ale_pkg::sts_type sts,
   output ale_pkg::ctl_type ctl
);

   ale_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ale_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      ctl        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == ale_pkg::S_IDLE);
      case (state_ff)
         ale_pkg::S_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = ale_pkg::S_CHECK;
            end
         end
         ale_pkg::S_CHECK: begin
            ctl.judge = 1'b1;
            state_in  = ale_pkg::S_FINISH;
            case (sts.cmd)
               ale_pkg::CMD_READ: begin
                  if (sts.chk == ale_pkg::ST_OK) begin
                     ctl.rd_issue = 1'b1;
                     state_in     = ale_pkg::S_RDWAIT;
                  end
               end
               ale_pkg::CMD_SEARCH: begin
                  ctl.begin_walk = 1'b1;
                  state_in       = ale_pkg::S_WALK;
               end
               ale_pkg::CMD_APPEND, ale_pkg::CMD_MODIFY: begin
                  if (sts.chk == ale_pkg::ST_OK) begin
                     ctl.put = 1'b1;
                     ctl.inc = (sts.cmd == ale_pkg::CMD_APPEND);
                  end
               end
               ale_pkg::CMD_INSERT, ale_pkg::CMD_REMOVE: begin
                  if (sts.chk == ale_pkg::ST_OK) begin
                     ctl.begin_walk = 1'b1;
                     state_in       = ale_pkg::S_WALK;
                  end
               end
               default: ;
            endcase
         end
         ale_pkg::S_RDWAIT: begin
            ctl.rd_grab = 1'b1;
            state_in    = ale_pkg::S_FINISH;
         end
         ale_pkg::S_WALK: begin
            ctl.walk = 1'b1;
            if (sts.done) begin
               // walk is over: place the new byte (insert) or drop the last slot (remove)
               ctl.put  = (sts.cmd == ale_pkg::CMD_INSERT);
               ctl.inc  = (sts.cmd == ale_pkg::CMD_INSERT);
               ctl.dec  = (sts.cmd == ale_pkg::CMD_REMOVE);
               state_in = ale_pkg::S_FINISH;
            end
         end
         ale_pkg::S_FINISH: begin
            if (sts.out_free) begin
               ctl.post = 1'b1;
               state_in = ale_pkg::S_IDLE;
            end
         end
         default: state_in = ale_pkg::S_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/ale_checker.sv -----
// port level checks of the array list engine, bound to the top level
`include "assert_macros.svh"

module ale_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [ale_pkg::RSP_W-1:0] rsp_tdata
);

   `ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_tvalid)

   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   `ASSERT_CLK(a_empty_matches_count, clock, reset,
      rsp_tvalid |-> (rsp_tdata[21] == (rsp_tdata[19:15] == 5'd0)))

   `ASSERT_CLK(a_full_empty_apart, clock, reset,
      rsp_tvalid |-> !(rsp_tdata[20] && rsp_tdata[21]))

   `ASSERT_CLK(a_hit_is_clean, clock, reset,
      rsp_tvalid && (rsp_tdata[12:8] != 5'h1f) |->
         (rsp_tdata[14:13] == 2'd0) && (rsp_tdata[7:0] == 8'd0))

endmodule

bind array_list_engine ale_checker u_ale_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/tb.sv -----
// self-checking testbench for the array list engine: random commands against a list predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // command word as packed on req_tdata, lowest field last
   typedef struct packed {
      logic                 pad;
      logic [7:0]           value;
      logic [3:0]           index;
      ale_pkg::cmd_type     cmd;
   } cmd_word_type;

   // result word as packed on rsp_tdata
   typedef struct packed {
      logic [1:0]                pad;
      logic                      empty;
      logic                      full;
      logic [4:0]                cnt;
      ale_pkg::stat_type         st;
      logic [ale_pkg::FND_W-1:0] fnd;
      logic [7:0]                rd;
   } result_word_type;

   localparam int HOLD_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ale_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ale_pkg::RSP_W-1:0] rsp_tdata;

   array_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   cmd_word_type    cmd_backlog[$];
   result_word_type result_due[$];

   // predicted list contents and length
   logic [7:0] list_mem[ale_pkg::CAPACITY];
   int         list_len = 0;
   // list length as the command generator sees it
   int         gen_len = 0;
   bit         gen_grow = 1'b1;

   int  phase = 0;
   bit  hold_go = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  err_cnt = 0;

   function automatic ale_pkg::stat_type slot_check(input logic [3:0] idx);
      if (list_len == 0) return ale_pkg::ST_EMPTY;
      if (int'(idx) >= list_len) return ale_pkg::ST_RANGE;
      return ale_pkg::ST_OK;
   endfunction

   function automatic result_word_type list_apply(input cmd_word_type c);
      result_word_type o;
      int k;
      bit hit;
      o = '0;
      o.fnd = ale_pkg::FOUND_NONE;
      o.st = ale_pkg::ST_OK;
      hit = 1'b0;
      case (c.cmd)
         ale_pkg::CMD_READ: begin
            o.st = slot_check(c.index);
            if (o.st == ale_pkg::ST_OK) o.rd = list_mem[c.index];
         end
         ale_pkg::CMD_SEARCH: begin
            for (k = 0; k < list_len; k++) begin
               if (!hit && list_mem[k] == c.value) begin
                  o.fnd = k[ale_pkg::FND_W-1:0];
                  hit = 1'b1;
               end
            end
         end
         ale_pkg::CMD_APPEND: begin
            if (list_len >= ale_pkg::CAPACITY) o.st = ale_pkg::ST_FULL;
            else begin
               list_mem[list_len] = c.value;
               list_len++;
            end
         end
         ale_pkg::CMD_INSERT: begin
            if (list_len >= ale_pkg::CAPACITY) o.st = ale_pkg::ST_FULL;
            else if (int'(c.index) > list_len) o.st = ale_pkg::ST_RANGE;
            else begin
               for (k = list_len; k > int'(c.index); k--) list_mem[k] = list_mem[k-1];
               list_mem[c.index] = c.value;
               list_len++;
            end
         end
         ale_pkg::CMD_MODIFY: begin
            o.st = slot_check(c.index);
            if (o.st == ale_pkg::ST_OK) list_mem[c.index] = c.value;
         end
         ale_pkg::CMD_REMOVE: begin
            o.st = slot_check(c.index);
            if (o.st == ale_pkg::ST_OK) begin
               for (k = int'(c.index); k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
               list_len--;
            end
         end
         default: ;
      endcase
      o.cnt = list_len[4:0];
      o.full = (list_len == ale_pkg::CAPACITY);
      o.empty = (list_len == 0);
      return o;
   endfunction

   // command mix: growing favors append and insert, shrinking favors remove
   function automatic ale_pkg::cmd_type pick_cmd(input bit grow, input int roll);
      if (grow) begin
         if (roll < 35) return ale_pkg::CMD_APPEND;
         if (roll < 55) return ale_pkg::CMD_INSERT;
         if (roll < 63) return ale_pkg::CMD_REMOVE;
         if (roll < 75) return ale_pkg::CMD_READ;
         if (roll < 87) return ale_pkg::CMD_SEARCH;
         return ale_pkg::CMD_MODIFY;
      end
      if (roll < 8) return ale_pkg::CMD_APPEND;
      if (roll < 16) return ale_pkg::CMD_INSERT;
      if (roll < 50) return ale_pkg::CMD_REMOVE;
      if (roll < 66) return ale_pkg::CMD_READ;
      if (roll < 82) return ale_pkg::CMD_SEARCH;
      return ale_pkg::CMD_MODIFY;
   endfunction

   task automatic queue_cmd(input ale_pkg::cmd_type c, input int idx, input int val);
      cmd_word_type w;
      w.pad = 1'b0;
      w.cmd = c;
      w.index = idx[3:0];
      w.value = val[7:0];
      case (c)
         ale_pkg::CMD_APPEND: if (gen_len < ale_pkg::CAPACITY) gen_len++;
         ale_pkg::CMD_INSERT: if (gen_len < ale_pkg::CAPACITY && idx <= gen_len) gen_len++;
         ale_pkg::CMD_REMOVE: if (gen_len > 0 && idx < gen_len) gen_len--;
         default: ;
      endcase
      cmd_backlog.push_back(w);
   endtask

   // mostly well-formed commands that swing the list between empty and full
   task automatic queue_random(input int n);
      int i;
      int roll;
      int idx;
      int val;
      ale_pkg::cmd_type c;
      for (i = 0; i < n; i++) begin
         if (gen_len == ale_pkg::CAPACITY) gen_grow = 1'b0;
         if (gen_len == 0) gen_grow = 1'b1;
         if ($urandom_range(0, 99) < 2) gen_grow = ~gen_grow;
         val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
         if ($urandom_range(0, 99) < 8) begin
            c = ale_pkg::cmd_type'($urandom_range(0, 5));
            idx = $urandom_range(0, 15);
         end else begin
            roll = $urandom_range(0, 99);
            c = pick_cmd(gen_grow, roll);
            if (c == ale_pkg::CMD_INSERT)
               idx = $urandom_range(0, gen_len < 15 ? gen_len : 15);
            else
               idx = gen_len > 0 ? $urandom_range(0, gen_len - 1) : 0;
         end
         queue_cmd(c, idx, val);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_tvalid || result_due.size() != 0);
   endtask

   task automatic note_bad(input string what, input int unsigned want, input int unsigned got);
      err_cnt++;
      if (err_cnt <= 10)
         $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   // sender: next word from the backlog, idling at random in phases 0 and 1
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            result_due.push_back(list_apply(cmd_word_type'(req_tdata)));
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 &&
                $urandom_range(0, 99) >= (phase == 0 ? 21 : phase == 1 ? 57 : 0)) begin
               req_tdata <= cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver stall, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // receiver: check each word, stall at random in phases 0 and 1 and during the long hold
   always @(posedge clock) begin
      result_word_type got;
      result_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_word_type'(rsp_tdata);
            if (result_due.size() == 0) begin
               note_bad("unexpected word", 0, rsp_tdata);
            end else begin
               want = result_due.pop_front();
               if (got.rd !== want.rd) note_bad("read_value", want.rd, got.rd);
               if (got.fnd !== want.fnd) note_bad("found_index", want.fnd, got.fnd);
               if (got.st !== want.st) note_bad("status", want.st, got.st);
               if (got.cnt !== want.cnt) note_bad("count", want.cnt, got.cnt);
               if (got.full !== want.full) note_bad("is_full", want.full, got.full);
               if (got.empty !== want.empty) note_bad("is_empty", want.empty, got.empty);
            end
         end
         if (hold_left > 0 || (hold_go && !hold_done)) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(0, 99) >= (phase == 0 ? 57 : phase == 1 ? 21 : 0);
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // empty list cases
      queue_cmd(ale_pkg::CMD_READ, 0, 0);
      queue_cmd(ale_pkg::CMD_REMOVE, 0, 0);
      queue_cmd(ale_pkg::CMD_MODIFY, 0, 8'h55);
      queue_cmd(ale_pkg::CMD_SEARCH, 0, 0);
      queue_cmd(ale_pkg::CMD_INSERT, 1, 8'h11);
      // insert at start, append, insert at the end
      queue_cmd(ale_pkg::CMD_INSERT, 0, 8'hff);
      queue_cmd(ale_pkg::CMD_APPEND, 15, 8'h00);
      queue_cmd(ale_pkg::CMD_INSERT, 2, 8'h80);
      queue_cmd(ale_pkg::CMD_READ, 15, 0);
      queue_cmd(ale_pkg::CMD_READ, 0, 0);
      queue_cmd(ale_pkg::CMD_READ, 2, 0);
      queue_cmd(ale_pkg::CMD_SEARCH, 0, 8'h80);
      queue_cmd(ale_pkg::CMD_SEARCH, 0, 8'h7f);
      queue_cmd(ale_pkg::CMD_MODIFY, 3, 8'h01);
      queue_cmd(ale_pkg::CMD_MODIFY, 1, 8'h7f);
      queue_cmd(ale_pkg::CMD_SEARCH, 0, 8'h7f);
      // remove first, then the tail, then an index out of range
      queue_cmd(ale_pkg::CMD_REMOVE, 0, 0);
      queue_cmd(ale_pkg::CMD_REMOVE, 1, 0);
      queue_cmd(ale_pkg::CMD_REMOVE, 5, 0);
      wait_drained();
      queue_random(ITEMS_PER_PHASE);
      wait_drained();
      phase <= 1;
      hold_go <= 1'b1;
      queue_random(ITEMS_PER_PHASE);
      wait_drained();
      phase <= 2;
      queue_random(ITEMS_PER_PHASE);
      wait_drained();
      repeat (40) @(negedge clock);
      if (err_cnt == 0)
         $display("[array_list_engine] OK");
      else
         $display("[array_list_engine] ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[array_list_engine] ERROR");
      $finish;
   end

endmodule
